@@ src/rtt_pkg.sv @@
// ============================================================================
// rtt_pkg: ranging tag table shared definitions
// Field widths, opcodes, register indexes and the command passed from the
// front (decode) to the back (table) through the command queue.
// ============================================================================
package rtt_pkg;

    // Table size default
    localparam int TAG_SLOTS_DEF = 3;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 64;
    localparam int RANGE_W  = 18;
    localparam int TIME_W   = 32;
    localparam int OFFSET_W = 16;
    localparam int DIST_W   = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 88;

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_RANGE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INACTIVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_OFFSET    = 2'd1;

    // Configuration reset values
    localparam logic [TIME_W-1:0]   REPORT_INTERVAL_RST = 32'd1000;
    localparam logic [OFFSET_W-1:0] RANGE_OFFSET_RST    = 16'd0;

    // Command kinds after decode
    typedef enum logic [1:0] {
        K_RANGE,
        K_INACTIVE,
        K_TICK
    } kind_t;

    // Command carried from front to back
    typedef struct packed {
        kind_t                    kind;
        logic [ADDR_W-1:0]        addr;
        logic signed [DIST_W-1:0] dist_mm;
        logic [TIME_W-1:0]        now;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } back_state_t;

endpackage

@@ src/rtt_front.sv @@
// ============================================================================
// rtt_front: request decode and command queue
// Accepts input requests, applies the range calibration offset, drops
// reserved opcodes and queues commands for the table back end.
// ============================================================================
module rtt_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rtt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rtt_pkg::OPCODE_W-1:0]  s_tuser,
    input  logic [rtt_pkg::OFFSET_W-1:0]  range_offset_mm,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output rtt_pkg::cmd_t                cmd
);
    import rtt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ADDR_W-1:0]  device_address;
    logic [RANGE_W-1:0] range_mm;
    logic [TIME_W-1:0]  now_ms;
    logic               in_fire;
    logic               push;
    logic               pop;
    logic               cmd_known;
    cmd_t               cmd_in;

    cmd_t               q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Unpack the request
    assign device_address = s_tdata[ADDR_W-1:0];
    assign range_mm       = s_tdata[ADDR_W+RANGE_W-1:ADDR_W];
    assign now_ms         = s_tdata[ADDR_W+RANGE_W+TIME_W-1:ADDR_W+RANGE_W];

    // Classify the request and compute the calibrated distance
    always_comb
    begin
        cmd_known      = 1'b1;
        cmd_in.kind    = K_RANGE;
        cmd_in.addr    = device_address;
        cmd_in.dist_mm = DIST_W'({1'b0, range_mm}) - DIST_W'(range_offset_mm);
        cmd_in.now     = now_ms;
        case (s_tuser)
            OP_RANGE:    cmd_in.kind = K_RANGE;
            OP_INACTIVE: cmd_in.kind = K_INACTIVE;
            OP_TICK:     cmd_in.kind = K_TICK;
            default:     cmd_known   = 1'b0;
        endcase
    end

    assign s_tready  = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign in_fire   = s_tvalid && s_tready;
    assign push      = in_fire && cmd_known;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store queued command payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ src/rtt_back.sv @@
// ============================================================================
// rtt_back: tag table and report sequencer
// Holds the ordered tag table, executes update, append, remove and tick
// commands, and streams a report one entry per cycle while m_tready is high
// through an output register.
// ============================================================================
module rtt_back
#(
    parameter int TAG_SLOTS = rtt_pkg::TAG_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rtt_pkg::cmd_t                 cmd,
    input  logic [rtt_pkg::TIME_W-1:0]    report_interval_ms,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rtt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import rtt_pkg::*;

    localparam int CNT_W = $clog2(TAG_SLOTS + 1);
    localparam int IDX_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

    back_state_t              state_reg, state_next;

    logic [ADDR_W-1:0]        slot_addr_reg [TAG_SLOTS];
    logic [ADDR_W-1:0]        slot_addr_next [TAG_SLOTS];
    logic signed [DIST_W-1:0] slot_dist_reg [TAG_SLOTS];
    logic signed [DIST_W-1:0] slot_dist_next [TAG_SLOTS];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [TIME_W-1:0]        last_time_reg, last_time_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;

    logic                     out_valid_reg;
    logic [ADDR_W-1:0]        out_addr_reg;
    logic signed [DIST_W-1:0] out_dist_reg;
    logic                     out_last_reg;

    logic [TAG_SLOTS-1:0]     hit;
    logic [TAG_SLOTS-1:0]     first_hit;
    logic [TAG_SLOTS-1:0]     at_or_after;
    logic                     any_hit;
    logic                     seen;
    logic                     exec;
    logic                     report_due;
    logic                     out_free;
    logic                     emit;
    logic                     emit_last;

    // Match the command address against the live entries
    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < TAG_SLOTS; i++)
        begin
            hit[i]         = (CNT_W'(i) < count_reg) && (slot_addr_reg[i] == cmd.addr);
            first_hit[i]   = hit[i] && !seen;
            seen           = seen | hit[i];
            at_or_after[i] = seen;
        end
        any_hit = seen;
    end

    assign exec       = cmd_valid && cmd_ready;
    assign report_due = (cmd.now - last_time_reg) >= report_interval_ms;
    assign out_free   = !out_valid_reg || m_tready;
    assign emit_last  = (CNT_W'(rd_idx_reg) + 1'b1) == count_reg;

    // Sequencer outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            ST_IDLE:   cmd_ready = 1'b1;
            ST_REPORT: emit      = out_free;
            default:   cmd_ready = 1'b0;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (exec && cmd.kind == K_TICK && report_due && count_reg != '0)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (emit && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Execute table commands and advance the report index
    always_comb
    begin
        slot_addr_next = slot_addr_reg;
        slot_dist_next = slot_dist_reg;
        count_next     = count_reg;
        last_time_next = last_time_reg;
        rd_idx_next    = rd_idx_reg;
        if (exec)
        begin
            case (cmd.kind)
                K_RANGE:
                begin
                    if (any_hit)
                    begin
                        for (int i = 0; i < TAG_SLOTS; i++)
                        begin
                            if (first_hit[i])
                            begin
                                slot_dist_next[i] = cmd.dist_mm;
                            end
                        end
                    end
                    else if (count_reg < CNT_W'(TAG_SLOTS))
                    begin
                        slot_addr_next[count_reg[IDX_W-1:0]] = cmd.addr;
                        slot_dist_next[count_reg[IDX_W-1:0]] = cmd.dist_mm;
                        count_next = count_reg + 1'b1;
                    end
                end
                K_INACTIVE:
                begin
                    // Close the gap: every entry from the match on takes its successor
                    for (int i = 0; i + 1 < TAG_SLOTS; i++)
                    begin
                        if (at_or_after[i] && (CNT_W'(i + 1) < count_reg))
                        begin
                            slot_addr_next[i] = slot_addr_reg[i + 1];
                            slot_dist_next[i] = slot_dist_reg[i + 1];
                        end
                    end
                    if (any_hit)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                K_TICK:
                begin
                    if (report_due)
                    begin
                        last_time_next = cmd.now;
                        rd_idx_next    = '0;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        if (emit)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_time_reg <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_time_reg <= last_time_next;
            rd_idx_reg    <= rd_idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold table payload and load the output register
    always_ff @(posedge clk)
    begin
        slot_addr_reg <= slot_addr_next;
        slot_dist_reg <= slot_dist_next;
        if (emit)
        begin
            out_addr_reg <= slot_addr_reg[rd_idx_reg];
            out_dist_reg <= slot_dist_reg[rd_idx_reg];
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - ADDR_W - DIST_W)'(0), out_dist_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ src/ranging_tag_table_top.sv @@
// ============================================================================
// ranging_tag_table_top: ranging tag table
// Ordered table of tag addresses with their latest calibrated distance,
// reported on a millisecond tick once the report interval has elapsed.
// ============================================================================
// Usage:
//   Input stream (s_*): one request per accepted beat; s_tuser carries the
//   opcode (range, inactive, tick), s_tdata the address, range and time.
//   Output stream (m_*): one beat per reported table entry, in table order,
//   m_tlast on the last entry of a report. Range and inactive requests and
//   ticks that are not yet due give no output.
//   Config channel (cfg_*): always ready; index 0 sets the report interval,
//   index 1 the range offset. Write only while the block is idle.
// Flow and throughput:
//   Requests enter a two-entry command queue; the table engine executes one
//   command per cycle while no report is running, so range and inactive
//   requests then sustain one per cycle. A due tick holds the engine while it
//   loads each stored entry (up to TAG_SLOTS) into the output register, one
//   per cycle while m_tready is high.
// Reset: empties the table, clears the last report time, restores the
//   interval to 1000 ms and the offset to zero.
// Stall: the output register holds its beat while m_tready is low; the
//   engine waits, the queue fills, then s_tready drops.
// ============================================================================
module ranging_tag_table_top
#(
    parameter int TAG_SLOTS = rtt_pkg::TAG_SLOTS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] device_address, [81:64] range_mm, [113:82] now_ms, rest zero
    input  logic [rtt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [rtt_pkg::OPCODE_W-1:0]    s_tuser,
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] tag_address, [82:64] distance_mm (signed), rest zero
    output logic [rtt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rtt_pkg::*;

    logic [TIME_W-1:0]   interval_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                cmd_valid;
    logic                cmd_ready;
    cmd_t                cmd;

    assign cfg_ready = 1'b1;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= REPORT_INTERVAL_RST;
            offset_reg   <= RANGE_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REPORT_INTERVAL: interval_reg <= cfg_data[TIME_W-1:0];
                CFG_RANGE_OFFSET:    offset_reg   <= cfg_data[OFFSET_W-1:0];
                default:             interval_reg <= interval_reg;
            endcase
        end
    end

    rtt_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .range_offset_mm (offset_reg),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd)
    );

    rtt_back
    #(
        .TAG_SLOTS (TAG_SLOTS)
    )
    u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd_valid          (cmd_valid),
        .cmd_ready          (cmd_ready),
        .cmd                (cmd),
        .report_interval_ms (interval_reg),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tlast            (m_tlast)
    );

endmodule

@@ dv/ranging_tag_table_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ranging_tag_table_checker: scoreboard for the ranging tag table
// Watches the request, report and register channels of the block. It keeps
// its own copy of the tag table and both registers, works out the report
// beats of every accepted tick and compares each accepted beat field by
// field. It hands the mismatch count and the number of outstanding beats to
// the testbench top.
// ============================================================================
module ranging_tag_table_checker
#(
    parameter int TAG_SLOTS = rtt_pkg::TAG_SLOTS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [63:0] device_address, [81:64] range_mm, [113:82] now_ms, rest zero
    input  logic [rtt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [rtt_pkg::OPCODE_W-1:0]    s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] tag_address, [82:64] distance_mm (signed), rest zero
    input  logic [rtt_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              requests,
    output int                              beats
);

    import rtt_pkg::*;

    // One expected report beat
    typedef struct packed {
        logic [ADDR_W-1:0]        addr;
        logic signed [DIST_W-1:0] dist_mm;
        logic                     last;
    } tag_beat_t;

    // Predicted table and registers
    logic [ADDR_W-1:0]        tag_addr [TAG_SLOTS];
    logic signed [DIST_W-1:0] tag_dist [TAG_SLOTS];
    int                       tag_count;
    logic [TIME_W-1:0]        last_report_ms;
    logic [TIME_W-1:0]        interval_ms;
    logic [OFFSET_W-1:0]      offset_mm;

    // Beats still owed by the block, oldest first
    tag_beat_t report_q[$];

    int        n_err;
    int        n_req;
    int        n_beat;
    tag_beat_t want;

    // Advance the predicted table by one accepted request
    task automatic update_table(input logic [OPCODE_W-1:0] op,
                                input logic [ADDR_W-1:0] addr,
                                input logic [RANGE_W-1:0] range_mm,
                                input logic [TIME_W-1:0] now_ms);
        int                       hit;
        int                       i;
        logic signed [DIST_W-1:0] dist_mm;
        logic [TIME_W-1:0]        elapsed;
        tag_beat_t                b;
        hit = -1;
        for (i = 0; i < tag_count; i++)
        begin
            if (hit < 0 && tag_addr[i] == addr)
                hit = i;
        end
        case (op)
            OP_RANGE:
            begin
                dist_mm = $signed({1'b0, range_mm}) - $signed({3'b0, offset_mm});
                if (hit >= 0)
                    tag_dist[hit] = dist_mm;
                else if (tag_count < TAG_SLOTS)
                begin
                    tag_addr[tag_count] = addr;
                    tag_dist[tag_count] = dist_mm;
                    tag_count++;
                end
            end
            OP_INACTIVE:
            begin
                // close the gap, keeping the order of later entries
                if (hit >= 0)
                begin
                    for (i = hit; i + 1 < tag_count; i++)
                    begin
                        tag_addr[i] = tag_addr[i + 1];
                        tag_dist[i] = tag_dist[i + 1];
                    end
                    tag_count--;
                end
            end
            OP_TICK:
            begin
                elapsed = now_ms - last_report_ms;
                if (elapsed >= interval_ms)
                begin
                    last_report_ms = now_ms;
                    for (i = 0; i < tag_count; i++)
                    begin
                        b.addr    = tag_addr[i];
                        b.dist_mm = tag_dist[i];
                        b.last    = (i + 1 == tag_count);
                        report_q.push_back(b);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_count      = 0;
            last_report_ms = '0;
            interval_ms    = REPORT_INTERVAL_RST;
            offset_mm      = RANGE_OFFSET_RST;
            report_q.delete();
            n_err          = 0;
            n_req          = 0;
            n_beat         = 0;
            errors   <= 0;
            pending  <= 0;
            requests <= 0;
            beats    <= 0;
        end
        else
        begin
            // Compare an accepted beat with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                n_beat++;
                if (report_q.size() == 0)
                begin
                    $error("unexpected report beat: tag_address %h", m_tdata[ADDR_W-1:0]);
                    n_err++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (m_tdata[ADDR_W-1:0] !== want.addr)
                    begin
                        $error("tag_address: expected %h, got %h",
                               want.addr, m_tdata[ADDR_W-1:0]);
                        n_err++;
                    end
                    if (m_tdata[ADDR_W +: DIST_W] !== want.dist_mm)
                    begin
                        $error("distance_mm: expected %0d, got %0d",
                               want.dist_mm, $signed(m_tdata[ADDR_W +: DIST_W]));
                        n_err++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("is_last: expected %0b, got %0b", want.last, m_tlast);
                        n_err++;
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REPORT_INTERVAL: interval_ms = cfg_data[TIME_W-1:0];
                    CFG_RANGE_OFFSET:    offset_mm   = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end

            // Predict from an accepted request
            if (s_tvalid && s_tready)
            begin
                n_req++;
                update_table(s_tuser, s_tdata[ADDR_W-1:0],
                             s_tdata[ADDR_W +: RANGE_W],
                             s_tdata[ADDR_W + RANGE_W +: TIME_W]);
            end

            errors   <= n_err;
            pending  <= report_q.size();
            requests <= n_req;
            beats    <= n_beat;
        end
    end

endmodule

@@ dv/ranging_tag_table_top_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ranging_tag_table_top_test: testbench for the ranging tag table
// Drives range, inactive, tick and unused-opcode requests: first a directed
// walk through empty, full and shifting tables and interval wrap, then
// random requests over a small address pool in four idling phases. The
// checker beside the block predicts and compares every report beat.
// ============================================================================
module ranging_tag_table_top_test;

    import rtt_pkg::*;

    localparam int                  SLOTS       = TAG_SLOTS_DEF;
    localparam int                  CYCLE_LIMIT = 200000;
    localparam int                  POOL_SIZE   = 5;
    localparam int                  PHASE_REQS  = 24;
    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OPCODE_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int requests;
    int beats;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_ms;

    ranging_tag_table_top #(.TAG_SLOTS(SLOTS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ranging_tag_table_checker #(.TAG_SLOTS(SLOTS)) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .requests  (requests),
        .beats     (beats)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the report stream at the current rate
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one request, idling first at the current rate; return on accept
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic [ADDR_W-1:0] addr,
                                input logic [RANGE_W-1:0] range_mm,
                                input logic [TIME_W-1:0] now_ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - ADDR_W - RANGE_W - TIME_W){1'b0}}, now_ms, range_mm, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off until every report beat has come and the engine has settled
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Write one register; call only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random request: mostly pool addresses so entries hit and fill
    task automatic random_request();
        int                  r;
        logic [ADDR_W-1:0]   addr;
        logic [OPCODE_W-1:0] op;
        logic [TIME_W-1:0]   now_ms;
        r = $urandom_range(99);
        if ($urandom_range(9) != 0)
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else
            addr = {$urandom, $urandom};
        if (r < 45)
            op = OP_RANGE;
        else if (r < 65)
            op = OP_INACTIVE;
        else if (r < 95)
            op = OP_TICK;
        else
            op = OP_UNUSED;
        now_ms = $urandom;
        if (op == OP_TICK)
        begin
            // advance the millisecond clock, now and then jump anywhere
            if ($urandom_range(19) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 120);
            now_ms = clock_ms;
        end
        send_request(op, addr, RANGE_W'($urandom_range(0, 262143)), now_ms);
    endtask

    initial
    begin
        int phase;
        int n;
        int k;

        // Hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: zero interval, largest offset
        write_reg(CFG_REPORT_INTERVAL, 32'd0);
        write_reg(CFG_RANGE_OFFSET, 32'h0000_FFFF);
        send_request(OP_TICK, '1, '1, 32'd5);                 // empty table report
        send_request(OP_RANGE, 64'd0, 18'd0, '1);             // most negative distance
        send_request(OP_RANGE, '1, 18'h3FFFF, '0);            // largest range
        send_request(OP_RANGE, 64'h0123_4567_89AB_CDEF, 18'd65535, 32'd0);
        send_request(OP_RANGE, 64'hFEDC_BA98_7654_3210, 18'd100, 32'd0); // full: drop
        send_request(OP_RANGE, 64'd0, 18'd12345, 32'd0);      // update in place
        send_request(OP_TICK, 64'h5555_5555_5555_5555, 18'h2AAAA, 32'd10);
        send_request(OP_INACTIVE, '1, 18'h15555, 32'h5555_5555);  // remove middle
        send_request(OP_TICK, '0, '0, 32'd20);
        send_request(OP_INACTIVE, 64'hDEAD_BEEF_0000_0001, '0, '0); // unknown address
        send_request(OP_UNUSED, 64'h0123_4567_89AB_CDEF, '1, '1);   // ignored opcode
        send_request(OP_INACTIVE, 64'd0, '0, '0);             // remove first
        send_request(OP_TICK, '0, '0, 32'd30);
        send_request(OP_INACTIVE, 64'h0123_4567_89AB_CDEF, '0, '0); // now empty
        send_request(OP_TICK, '0, '0, 32'd40);
        send_request(OP_RANGE, 64'hAAAA_AAAA_AAAA_AAAA, 18'd70000, 32'd0);
        send_request(OP_TICK, '0, '0, 32'd50);
        wait_drain();

        // Directed: largest interval, zero offset, wrapping time difference
        write_reg(CFG_REPORT_INTERVAL, 32'hFFFF_FFFF);
        write_reg(CFG_RANGE_OFFSET, 32'd0);
        send_request(OP_RANGE, 64'h8000_0000_0000_0001, 18'd7, 32'd0);
        send_request(OP_TICK, '0, '0, 32'd49);                // due by wraparound
        send_request(OP_TICK, '0, '0, 32'd49);                // not due
        send_request(OP_TICK, '0, '0, 32'd48);                // due again
        send_request(OP_TICK, '0, '0, 32'hFFFF_FFFF);         // short of interval
        wait_drain();

        // Random phases: none, sender idle, receiver stall, both
        clock_ms = $urandom;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (k = 0; k < POOL_SIZE; k++)
                addr_pool[k] = {$urandom, $urandom};
            write_reg(CFG_REPORT_INTERVAL, (phase == 0) ? 32'd0 : $urandom_range(10, 150));
            write_reg(CFG_RANGE_OFFSET, (phase == 3) ? 32'h0000_FFFF : $urandom_range(0, 65535));
            for (n = 0; n < PHASE_REQS; n++)
            begin
                // pause mid-phase until the block has caught up
                if (phase == 2 && n == PHASE_REQS / 2)
                    wait_drain();
                random_request();
            end
            wait_drain();
        end

        $display("summary: %0d requests and %0d report beats checked, directed table cases",
                 requests, beats);
        $display("summary: then random traffic under four idling and stall mixes");
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
